[hw/rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

    // Cursor widths fixed by the screen geometry limits.
    localparam int unsigned ROW_W   = 5;
    localparam int unsigned COL_W   = 7;
    localparam int unsigned INDEX_W = 11;

    // Request and result field widths.
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned NUM_W    = 32;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned COLOUR_W = 8;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 32;

    // Up to ten characters per request; the counter needs four bits.
    localparam int unsigned MAX_CHARS = 10;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned DIGIT_W   = 4;

    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'h07;
    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]   CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0]   CHAR_X       = 8'h78;
    localparam logic [CNT_W-1:0]    HEX_LEN      = 4'd10;
    localparam logic [CNT_W-1:0]    HEX_X_LEFT   = 4'd9;

    // Reciprocal of ten: floor(n * RECIP_TEN / 2^35) equals n / 10 for 32-bit n.
    localparam logic [NUM_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned      RECIP_SHIFT = 35;
    localparam int unsigned      QUOT_W      = 2 * NUM_W - RECIP_SHIFT;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR = 2'd0,
        KIND_DEC  = 2'd1,
        KIND_HEX  = 2'd2
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_EMIT
    } t_state;

    // Cursor commands from the sequencer.
    typedef struct packed {
        logic step;
        logic newline;
    } t_cur_cmd;

    // Uppercase hex glyph for one nibble.
    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [DIGIT_W-1:0] nib);
        logic [CHAR_W-1:0] g;
        case (nib)
            4'h0: g = 8'h30;
            4'h1: g = 8'h31;
            4'h2: g = 8'h32;
            4'h3: g = 8'h33;
            4'h4: g = 8'h34;
            4'h5: g = 8'h35;
            4'h6: g = 8'h36;
            4'h7: g = 8'h37;
            4'h8: g = 8'h38;
            4'h9: g = 8'h39;
            4'hA: g = 8'h41;
            4'hB: g = 8'h42;
            4'hC: g = 8'h43;
            4'hD: g = 8'h44;
            4'hE: g = 8'h45;
            default: g = 8'h46;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/text_console_writer_core.sv]
`default_nettype none

// Channel      Direction  Contents
// s_axis       in         tuser: req_type; tdata: char_code, number
// m_axis       out        tdata: cell_index, cell_word; tlast: last_write
// cfg          in         i_cfg_wr_en / i_cfg_wr_data: text_colour
//
// A character is accepted and then emitted as one cell; a newline only moves the cursor.
// Hex is accepted and then emits ten cells, one per cycle while the output slot is free.
// Decimal passes each digit through the divide-by-ten states ST_MUL and ST_SUB,
// then emits the digits, most significant first: up to ten digits.
// Emission waits while the output register holds a write m_axis has not taken.
// Reset is synchronous: cursor at the top left, colour 7, no result pending.
module text_console_writer_core #(
    parameter int unsigned SCREEN_WIDTH  = 80,
    parameter int unsigned SCREEN_HEIGHT = 25
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Request channel.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata bits 7..0 char_code, 39..8 number.
    input  wire logic [tcw_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // tuser bits 1..0 req_type.
    input  wire logic [tcw_pkg::KIND_W-1:0]       s_axis_tuser,
    // Cell write channel.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata bits 10..0 cell_index, 26..11 cell_word, 31..27 zero.
    output logic      [tcw_pkg::M_DATA_W-1:0]     m_axis_tdata,
    output logic                                  m_axis_tlast,
    // Colour register write.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [tcw_pkg::COLOUR_W-1:0]     i_cfg_wr_data
);

    tcw_pkg::t_state    r_state, n_state;
    tcw_pkg::t_req_kind r_kind;
    tcw_pkg::t_req_kind w_in_kind;
    tcw_pkg::t_cur_cmd  w_cmd;

    logic [tcw_pkg::COLOUR_W-1:0] r_colour;
    logic [tcw_pkg::CHAR_W-1:0]   r_char;
    logic [tcw_pkg::NUM_W-1:0]    r_num;
    logic [tcw_pkg::CNT_W-1:0]    r_left;
    logic [tcw_pkg::DIGIT_W-1:0]  r_dig [tcw_pkg::MAX_CHARS];

    logic                         r_out_valid;
    logic [tcw_pkg::INDEX_W-1:0]  r_out_index;
    logic [tcw_pkg::WORD_W-1:0]   r_out_word;
    logic                         r_out_last;

    logic                         w_accept;
    logic                         w_slot_free;
    logic                         w_emit;
    logic [tcw_pkg::CHAR_W-1:0]   w_in_char;
    logic [tcw_pkg::NUM_W-1:0]    w_in_num;
    logic [tcw_pkg::CNT_W-1:0]    w_dig_idx;
    logic [tcw_pkg::CHAR_W-1:0]   w_glyph;
    logic [tcw_pkg::NUM_W-1:0]    w_quot;
    logic [tcw_pkg::DIGIT_W-1:0]  w_rem;
    logic [tcw_pkg::INDEX_W-1:0]  w_index;

    assign w_in_kind   = tcw_pkg::t_req_kind'(s_axis_tuser);
    assign w_in_char   = s_axis_tdata[tcw_pkg::CHAR_W-1:0];
    assign w_in_num    = s_axis_tdata[tcw_pkg::CHAR_W +: tcw_pkg::NUM_W];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_dig_idx   = r_left - 1'b1;

    tcw_dec_unit u_dec (
        .i_clk      (i_clk),
        .i_dividend (r_num),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    tcw_cursor #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_index (w_index)
    );

    // Character shown by the current emission.
    always_comb begin
        case (r_kind)
            tcw_pkg::KIND_CHAR: w_glyph = r_char;
            tcw_pkg::KIND_DEC:  w_glyph = tcw_pkg::CHAR_ZERO
                                          + tcw_pkg::CHAR_W'(r_dig[w_dig_idx]);
            tcw_pkg::KIND_HEX: begin
                if (r_left == tcw_pkg::HEX_LEN) begin
                    w_glyph = tcw_pkg::CHAR_ZERO;
                end else if (r_left == tcw_pkg::HEX_X_LEFT) begin
                    w_glyph = tcw_pkg::CHAR_X;
                end else begin
                    w_glyph = tcw_pkg::hex_glyph(r_num[tcw_pkg::NUM_W-1 -: tcw_pkg::DIGIT_W]);
                end
            end
            default: w_glyph = r_char;
        endcase
    end

    // Sequencer: next state, handshake and cursor commands.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = (r_state == tcw_pkg::ST_IDLE);
        w_emit        = 1'b0;
        w_cmd         = '0;
        case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_in_kind)
                        tcw_pkg::KIND_CHAR: begin
                            if (w_in_char == tcw_pkg::NEWLINE_CODE) begin
                                w_cmd.newline = 1'b1;
                            end else begin
                                n_state = tcw_pkg::ST_EMIT;
                            end
                        end
                        tcw_pkg::KIND_DEC: n_state = tcw_pkg::ST_MUL;
                        tcw_pkg::KIND_HEX: n_state = tcw_pkg::ST_EMIT;
                        default:           n_state = tcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tcw_pkg::ST_MUL: n_state = tcw_pkg::ST_SUB;
            tcw_pkg::ST_SUB: begin
                if (w_quot == '0) begin
                    n_state = tcw_pkg::ST_EMIT;
                end else begin
                    n_state = tcw_pkg::ST_MUL;
                end
            end
            tcw_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    w_emit     = 1'b1;
                    w_cmd.step = 1'b1;
                    if (r_left == 4'd1) begin
                        n_state = tcw_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Colour register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= tcw_pkg::COLOUR_RESET;
        end else if (i_cfg_wr_en) begin
            r_colour <= i_cfg_wr_data;
        end
    end

    // Request working registers and digit store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_accept) begin
            r_kind <= w_in_kind;
            r_char <= w_in_char;
            r_num  <= w_in_num;
            case (w_in_kind)
                tcw_pkg::KIND_CHAR: r_left <= 4'd1;
                tcw_pkg::KIND_HEX:  r_left <= tcw_pkg::HEX_LEN;
                default:            r_left <= '0;
            endcase
        end else if (r_state == tcw_pkg::ST_SUB) begin
            r_dig[r_left] <= w_rem;
            r_left        <= r_left + 1'b1;
            r_num         <= w_quot;
        end else if (w_emit) begin
            r_left <= w_dig_idx;
            // Hex digits leave from the top nibble once the prefix is out.
            if (r_kind == tcw_pkg::KIND_HEX && r_left < tcw_pkg::HEX_X_LEFT) begin
                r_num <= r_num << tcw_pkg::DIGIT_W;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_index <= w_index;
            r_out_word  <= {r_colour, w_glyph};
            r_out_last  <= (r_left == 4'd1);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {
        (tcw_pkg::M_DATA_W - tcw_pkg::WORD_W - tcw_pkg::INDEX_W)'(0),
        r_out_word, r_out_index
    };

endmodule

`default_nettype wire

[hw/rtl/tcw_dec_unit.sv]
`default_nettype none

// Divide-by-ten unit: a registered reciprocal multiply, then the quotient
// and remainder are formed from the product and the held dividend.
module tcw_dec_unit (
    input  wire logic                                i_clk,
    input  wire logic [tcw_pkg::NUM_W-1:0]           i_dividend,
    output logic      [tcw_pkg::NUM_W-1:0]           o_quot,
    output logic      [tcw_pkg::DIGIT_W-1:0]         o_rem
);

    logic [2*tcw_pkg::NUM_W-1:0] r_prod;
    logic [tcw_pkg::NUM_W-1:0]   w_times_ten;
    logic [tcw_pkg::NUM_W-1:0]   w_diff;

    // Product register; the dividend must stay stable for the following cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_dividend) * 64'(tcw_pkg::RECIP_TEN);
    end

    // Quotient from the high product bits, remainder by shift and add.
    always_comb begin
        o_quot      = tcw_pkg::NUM_W'(r_prod[2*tcw_pkg::NUM_W-1:tcw_pkg::RECIP_SHIFT]);
        w_times_ten = (o_quot << 3) + (o_quot << 1);
        w_diff      = i_dividend - w_times_ten;
        o_rem       = w_diff[tcw_pkg::DIGIT_W-1:0];
    end

endmodule

`default_nettype wire

[hw/rtl/tcw_cursor.sv]
`default_nettype none

// Row and column cursor with wrap, and the cell index it addresses.
module tcw_cursor #(
    parameter int unsigned SCREEN_WIDTH  = 80,
    parameter int unsigned SCREEN_HEIGHT = 25
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcw_pkg::t_cur_cmd             i_cmd,
    output logic [tcw_pkg::INDEX_W-1:0]        o_index
);

    localparam int unsigned SUM_W = tcw_pkg::ROW_W + tcw_pkg::COL_W;

    logic [tcw_pkg::ROW_W-1:0] r_row, n_row;
    logic [tcw_pkg::COL_W-1:0] r_col, n_col;
    logic [tcw_pkg::ROW_W:0]   w_row_inc;
    logic [tcw_pkg::COL_W:0]   w_col_inc;
    logic [tcw_pkg::ROW_W-1:0] w_row_adv;
    logic [SUM_W-1:0]          w_sum;

    // Next cursor position.
    always_comb begin
        w_row_inc = {1'b0, r_row} + 1'b1;
        w_col_inc = {1'b0, r_col} + 1'b1;
        if (w_row_inc >= (tcw_pkg::ROW_W+1)'(SCREEN_HEIGHT)) begin
            w_row_adv = '0;
        end else begin
            w_row_adv = w_row_inc[tcw_pkg::ROW_W-1:0];
        end
        n_row = r_row;
        n_col = r_col;
        if (i_cmd.newline) begin
            n_col = '0;
            n_row = w_row_adv;
        end else if (i_cmd.step) begin
            if (w_col_inc >= (tcw_pkg::COL_W+1)'(SCREEN_WIDTH)) begin
                n_col = '0;
                n_row = w_row_adv;
            end else begin
                n_col = w_col_inc[tcw_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Cell index, row times width plus column, kept to its low bits.
    always_comb begin
        w_sum   = SUM_W'(r_row) * SUM_W'(SCREEN_WIDTH) + SUM_W'(r_col);
        o_index = w_sum[tcw_pkg::INDEX_W-1:0];
    end

endmodule

`default_nettype wire

[tb/text_console_writer_core_tb.sv]
`timescale 1ns / 1ps

module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam int unsigned SCR_W = 80;
    localparam int unsigned SCR_H = 25;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned LONG_STALL_CYCLES = 300;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic [NUM_W-1:0]  num;
    } console_req_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  word;
        logic               last;
    } cell_write_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // tdata bits 7..0 char_code, 39..8 number.
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    // tuser bits 1..0 req_type.
    logic [KIND_W-1:0]   s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // tdata bits 10..0 cell_index, 26..11 cell_word, 31..27 zero.
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;
    logic                i_cfg_wr_en = 1'b0;
    logic [COLOUR_W-1:0] i_cfg_wr_data = '0;

    // Requests waiting to be offered, and cell writes the console must still produce.
    console_req_t console_requests[$];
    cell_write_t  cell_writes_due[$];

    // Predicted console state.
    int unsigned         cur_row = 0;
    int unsigned         cur_col = 0;
    logic [COLOUR_W-1:0] text_colour = COLOUR_RESET;

    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 63;
    logic        long_stall_arm = 1'b0;
    logic        long_stall_done = 1'b0;
    int unsigned long_stall_cnt = 0;
    int unsigned mismatch_count = 0;

    text_console_writer_core #(
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predict one glyph: a write at the cursor, then advance with wrap.
    task automatic print_glyph(input logic [CHAR_W-1:0] glyph);
        cell_write_t w;
        int unsigned idx;
        idx = cur_row * SCR_W + cur_col;
        w.index = idx[INDEX_W-1:0];
        w.word = {text_colour, glyph};
        w.last = 1'b0;
        cell_writes_due.push_back(w);
        cur_col = cur_col + 1;
        if (cur_col >= SCR_W) begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= SCR_H) ? 0 : cur_row + 1;
        end
    endtask

    task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                                 input logic [NUM_W-1:0] num);
        console_req_t r;
        r.kind = kind;
        r.ch = ch;
        r.num = num;
        console_requests.push_back(r);
    endtask

    // Random requests: mostly printable work, with newlines often enough to wrap the rows.
    task automatic queue_random(input int unsigned count);
        int unsigned pick;
        int unsigned digits;
        logic [NUM_W-1:0] scale;
        logic [NUM_W-1:0] value;
        for (int unsigned k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            value = $urandom;
            if (pick < 20) begin
                queue_request(KIND_CHAR, NEWLINE_CODE, value);
            end else if (pick < 40) begin
                queue_request(KIND_CHAR, 8'($urandom), value);
            end else if (pick < 65) begin
                // Short numbers are as interesting as ten-digit ones.
                if ($urandom_range(0, 3) != 0) begin
                    digits = $urandom_range(1, 9);
                    scale = 1;
                    repeat (digits) scale = scale * 10;
                    value = value % scale;
                end
                queue_request(KIND_DEC, 8'($urandom), value);
            end else if (pick < 92) begin
                queue_request(KIND_HEX, 8'($urandom), value);
            end else begin
                queue_request(KIND_UNUSED, 8'($urandom), value);
            end
        end
    endtask

    // Wait until every request is taken and every cell write has come back.
    task automatic wait_drained();
        while (console_requests.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (cell_writes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_colour(input logic [COLOUR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        text_colour = value;
    endtask

    // Request driver: holds an offered request until it is taken.
    always @(posedge i_clk) begin : request_driver
        console_req_t req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (console_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req = console_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= req.kind;
                s_axis_tdata <= {req.num, req.ch};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Cell write receiver: random back-pressure, plus one long hold-off when armed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_stall_arm && !long_stall_done) begin
            m_axis_tready <= 1'b0;
            if (long_stall_cnt == LONG_STALL_CYCLES) begin
                long_stall_done <= 1'b1;
            end
            long_stall_cnt <= long_stall_cnt + 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts cell writes for each taken request and checks each cell write.
    always @(posedge i_clk) begin : console_monitor
        logic [CHAR_W-1:0]  ch;
        logic [NUM_W-1:0]   num;
        logic [NUM_W-1:0]   rest;
        logic [CHAR_W-1:0]  dec_digits[MAX_CHARS];
        logic [DIGIT_W-1:0] nib;
        int                 ndig;
        int                 first;
        cell_write_t        want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                ch = s_axis_tdata[CHAR_W-1:0];
                num = s_axis_tdata[CHAR_W +: NUM_W];
                first = cell_writes_due.size();
                case (s_axis_tuser)
                    KIND_CHAR: begin
                        if (ch == NEWLINE_CODE) begin
                            cur_col = 0;
                            cur_row = (cur_row + 1 >= SCR_H) ? 0 : cur_row + 1;
                        end else begin
                            print_glyph(ch);
                        end
                    end
                    KIND_DEC: begin
                        // Digits are found least significant first and printed in reverse; zero gives one digit.
                        rest = num;
                        ndig = 0;
                        do begin
                            dec_digits[ndig] = CHAR_ZERO + 8'(rest % 10);
                            rest = rest / 10;
                            ndig++;
                        end while (rest != 0);
                        for (int j = ndig - 1; j >= 0; j--) print_glyph(dec_digits[j]);
                    end
                    KIND_HEX: begin
                        print_glyph(CHAR_ZERO);
                        print_glyph(CHAR_X);
                        for (int j = 7; j >= 0; j--) begin
                            nib = num[j*4 +: 4];
                            print_glyph(nib < 10 ? CHAR_ZERO + nib : 8'h37 + nib);
                        end
                    end
                    default: begin
                    end
                endcase
                if (cell_writes_due.size() > first) begin
                    cell_writes_due[cell_writes_due.size() - 1].last = 1'b1;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (cell_writes_due.size() == 0) begin
                    $display("%0t: unexpected cell write, index %0d word %h last %b", $time,
                             m_axis_tdata[INDEX_W-1:0], m_axis_tdata[INDEX_W +: WORD_W],
                             m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = cell_writes_due.pop_front();
                    if (m_axis_tdata[INDEX_W-1:0] !== want.index) begin
                        $display("%0t: cell_index expected %0d got %0d", $time, want.index,
                                 m_axis_tdata[INDEX_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[INDEX_W +: WORD_W] !== want.word) begin
                        $display("%0t: cell_word expected %h got %h", $time, want.word,
                                 m_axis_tdata[INDEX_W +: WORD_W]);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: last_write expected %b got %b", $time, want.last,
                                 m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset colour: field extremes and every special case.
        queue_request(KIND_CHAR, 8'h41, 32'hFFFF_FFFF);
        queue_request(KIND_CHAR, 8'h00, 32'h0);
        queue_request(KIND_CHAR, 8'hFF, 32'h0);
        queue_request(KIND_CHAR, NEWLINE_CODE, 32'hFFFF_FFFF);
        queue_request(KIND_UNUSED, 8'h41, 32'h1234_5678);
        queue_request(KIND_UNUSED, NEWLINE_CODE, 32'h0);
        queue_request(KIND_DEC, 8'hFF, 32'd0);
        queue_request(KIND_DEC, NEWLINE_CODE, 32'd1);
        queue_request(KIND_DEC, 8'h00, 32'd9);
        queue_request(KIND_DEC, 8'h00, 32'd10);
        queue_request(KIND_DEC, 8'h00, 32'd4294967295);
        queue_request(KIND_DEC, 8'h00, 32'd1000000000);
        queue_request(KIND_DEC, 8'h00, 32'd999999999);
        queue_request(KIND_HEX, 8'h00, 32'h0);
        queue_request(KIND_HEX, NEWLINE_CODE, 32'hFFFF_FFFF);
        queue_request(KIND_HEX, 8'h00, 32'h1234_5678);
        queue_request(KIND_HEX, 8'hFF, 32'h9ABC_DEF0);
        queue_request(KIND_CHAR, 8'h7A, 32'h0);
        queue_request(KIND_CHAR, NEWLINE_CODE, 32'h0);
        wait_drained();

        write_colour(8'h00);
        queue_random(33);
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 33;
        write_colour(8'hFF);
        queue_random(35);
        wait_drained();

        // No idling, and one long receiver hold-off while requests keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_colour(8'($urandom));
        queue_random(33);
        long_stall_arm = 1'b1;
        wait_drained();

        if (mismatch_count == 0) begin
            $display("text_console_writer_core_tb: clean");
        end else begin
            $display("text_console_writer_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("text_console_writer_core_tb: errors");
        $finish;
    end

endmodule
